// File: hdl/ptt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptt_pkg - shared types and codes for the periodic timer table
// Holds the item kind and status codes, the slot record layout and the
// write control group for the slot memory.
// ----------------------------------------------------------------------------
package ptt_pkg;

	localparam logic [1:0] KIND_ADD    = 2'd0;
	localparam logic [1:0] KIND_REMOVE = 2'd1;
	localparam logic [1:0] KIND_TICK   = 2'd2;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_INVALID = 2'd1;
	localparam logic [1:0] STAT_FULL    = 2'd2;

	typedef logic [3:0][31:0] args_t;

	typedef struct packed {
		logic [31:0] handler;
		logic [31:0] period;
		logic [31:0] due;
		args_t       args;
	} slot_rec_t;

	// full: write the whole slot; due_only: reload the due time
	typedef struct packed {
		logic full;
		logic due_only;
	} wr_ctl_t;

endpackage

// File: hdl/ptt_slot_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptt_slot_ram - slot storage of the periodic timer table
// One write port and one registered read port over handler, period, due
// time and argument words.
// ----------------------------------------------------------------------------
module ptt_slot_ram #(
	parameter int DEPTH  = 16,
	parameter int ADDR_W = 4
) (
	input  logic               clk,
	input  ptt_pkg::wr_ctl_t   wr,
	input  logic [ADDR_W-1:0]  waddr,
	input  ptt_pkg::slot_rec_t wdata,
	input  logic [ADDR_W-1:0]  raddr,
	output ptt_pkg::slot_rec_t rdata
);
	import ptt_pkg::*;

	logic [31:0] handler_mem [DEPTH];
	logic [31:0] period_mem  [DEPTH];
	logic [31:0] due_mem     [DEPTH];
	args_t       args_mem    [DEPTH];
	slot_rec_t   rd_q;

	always_ff @(posedge clk) begin
		if (wr.full) begin
			handler_mem[waddr] <= wdata.handler;
			period_mem[waddr]  <= wdata.period;
			args_mem[waddr]    <= wdata.args;
		end
		if (wr.full || wr.due_only) begin
			due_mem[waddr] <= wdata.due;
		end
	end

	always_ff @(posedge clk) begin
		rd_q.handler <= handler_mem[raddr];
		rd_q.period  <= period_mem[raddr];
		rd_q.due     <= due_mem[raddr];
		rd_q.args    <= args_mem[raddr];
	end

	assign rdata = rd_q;

endmodule

// File: hdl/ptt_due_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptt_due_unit - shared adder and due-time comparator
// Adds a step to the tick counter (wrapping) and compares a due time
// against the counter, unsigned.
// ----------------------------------------------------------------------------
module ptt_due_unit (
	input  logic [31:0] base,
	input  logic [31:0] step,
	input  logic [31:0] due,
	output logic [31:0] sum,
	output logic        due_lt
);
	assign sum    = base + step;
	assign due_lt = (due < base);

endmodule

// File: hdl/periodic_callback_timer_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_callback_timer_table_unit - periodic timer table with tick counter
// Adds and removes timer slots and, on each tick, fires every live slot
// whose due time has passed, one record per firing.
// ----------------------------------------------------------------------------
//
//  channel  handshake            payload
//  -------  -------------------  --------------------------------------------
//  request  req_valid/req_stall  kind, handler, period, arg_one..arg_four,
//                                slot_index
//  response rsp_valid/rsp_stall  status, slot_out, fired, fire_handler,
//                                fire_arg_one..fire_arg_four, last
//
//  Scan: a tick covers one slot per cycle, unless rsp_stall holds it,
//  through the single memory read port and the shared adder and
//  comparator. An add scans until it finds the first free slot; remove
//  and rejected adds skip the scan.
//  Reset: arst_n clears the counter, all slot valid bits and the handshakes;
//  a slot that is not valid is free, so the memory needs no clearing pass.
//  Stalls: rsp_stall holds the scan only when a second firing must leave
//  while the output register is still full; req_stall is high whenever a
//  transaction is in work.
// ----------------------------------------------------------------------------
module periodic_callback_timer_table_unit #(
	parameter int SLOT_COUNT = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  kind,
	input  logic [31:0] handler,
	input  logic [31:0] period,
	input  logic [31:0] arg_one,
	input  logic [31:0] arg_two,
	input  logic [31:0] arg_three,
	input  logic [31:0] arg_four,
	input  logic [7:0]  slot_index,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [1:0]  status,
	output logic [7:0]  slot_out,
	output logic        fired,
	output logic [31:0] fire_handler,
	output logic [31:0] fire_arg_one,
	output logic [31:0] fire_arg_two,
	output logic [31:0] fire_arg_three,
	output logic [31:0] fire_arg_four,
	output logic        last
);
	import ptt_pkg::*;

	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOT_COUNT - 1);
	localparam logic [7:0] SLOT_LIMIT = 8'(SLOT_COUNT);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	state_t              state_q;
	logic [IDX_W-1:0]    idx_q;
	logic [IDX_W-1:0]    idx_d;
	logic [SLOT_COUNT-1:0] valid_q;
	logic [31:0]         counter_q;

	// captured request
	logic [1:0]          kind_q;
	logic [31:0]         handler_q;
	logic [31:0]         period_q;
	args_t               args_q;

	// held firing, waiting to learn whether it is the last one
	logic                pend_valid_q;
	logic [IDX_W-1:0]    pend_slot_q;
	logic [31:0]         pend_handler_q;
	args_t               pend_args_q;

	// final record of non-firing transactions
	logic [1:0]          fin_status_q;
	logic [7:0]          fin_slot_q;

	// output register
	logic                rsp_valid_q;
	logic [1:0]          status_q;
	logic [7:0]          slot_out_q;
	logic                fired_q;
	logic [31:0]         fire_handler_q;
	args_t               fire_args_q;
	logic                last_q;

	logic                req_take;
	logic                out_free;
	logic                scan_add;
	logic                scan_tick;
	logic                scan_live;
	logic                scan_fire;
	logic                scan_end;
	logic                scan_go;
	logic                pend_load;
	logic                push_mid;
	logic                push_fin;
	logic [31:0]         step;
	logic [31:0]         sum;
	logic                due_lt;
	slot_rec_t           rd_rec;
	slot_rec_t           wr_rec;
	wr_ctl_t             wr;

	assign req_stall = (state_q != ST_IDLE);
	assign req_take  = req_valid && !req_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;

	// Scan control: one slot per cycle unless a held firing stalls the tick scan, read data for idx_q is always ready
	assign scan_add  = (state_q == ST_SCAN) && (kind_q == KIND_ADD);
	assign scan_tick = (state_q == ST_SCAN) && (kind_q != KIND_ADD);
	assign scan_live = valid_q[idx_q];
	assign scan_fire = scan_live && due_lt;
	assign scan_end  = (idx_q == IDX_LAST);

	// hold the tick scan only when a held firing has nowhere to go
	assign scan_go   = scan_add ||
		(scan_tick && !(scan_fire && pend_valid_q && !out_free));
	assign pend_load = scan_tick && scan_go && scan_fire;
	assign push_mid  = pend_load && pend_valid_q;
	assign push_fin  = (state_q == ST_FIN) && out_free;

	always_comb begin
		if (req_take) begin
			idx_d = '0;
		end else if ((state_q == ST_SCAN) && scan_go && !scan_end) begin
			idx_d = idx_q + 1'b1;
		end else begin
			idx_d = idx_q;
		end
	end

	// Shared adder: counter increment on a tick request, due time otherwise
	always_comb begin
		if (state_q == ST_IDLE) begin
			step = 32'd1;
		end else if (kind_q == KIND_ADD) begin
			step = period_q;
		end else begin
			step = rd_rec.period;
		end
	end

	ptt_due_unit u_due (
		.base   (counter_q),
		.step   (step),
		.due    (rd_rec.due),
		.sum    (sum),
		.due_lt (due_lt)
	);

	assign wr.full     = scan_add && !scan_live;
	assign wr.due_only = pend_load;
	assign wr_rec      = '{handler: handler_q, period: period_q, due: sum, args: args_q};

	ptt_slot_ram #(
		.DEPTH  (SLOT_COUNT),
		.ADDR_W (IDX_W)
	) u_ram (
		.clk   (clk),
		.wr    (wr),
		.waddr (idx_q),
		.wdata (wr_rec),
		.raddr (idx_d),
		.rdata (rd_rec)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			idx_q        <= '0;
			valid_q      <= '0;
			counter_q    <= '0;
			pend_valid_q <= 1'b0;
			fin_status_q <= STAT_OK;
			fin_slot_q   <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			idx_q <= idx_d;
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (push_mid || push_fin) begin
				rsp_valid_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_take) begin
						fin_status_q <= STAT_OK;
						fin_slot_q   <= '0;
						case (kind)
							KIND_ADD: begin
								if ((handler == '0) || (period == '0)) begin
									fin_status_q <= STAT_INVALID;
									state_q      <= ST_FIN;
								end else begin
									state_q <= ST_SCAN;
								end
							end
							KIND_REMOVE: begin
								if (slot_index < SLOT_LIMIT) begin
									valid_q[slot_index[IDX_W-1:0]] <= 1'b0;
								end
								state_q <= ST_FIN;
							end
							KIND_TICK: begin
								counter_q <= sum;
								state_q   <= ST_SCAN;
							end
							default: begin
								state_q <= ST_FIN;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (scan_add) begin
						// take the first free slot, or report full at the end
						if (!scan_live) begin
							valid_q[idx_q] <= 1'b1;
							fin_slot_q     <= 8'(idx_q);
							state_q        <= ST_FIN;
						end else if (scan_end) begin
							fin_status_q <= STAT_FULL;
							state_q      <= ST_FIN;
						end
					end else if (scan_go) begin
						if (scan_fire) begin
							pend_valid_q <= 1'b1;
						end
						if (scan_end) begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_FIN: begin
					if (out_free) begin
						pend_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request capture and held firing
	always_ff @(posedge clk) begin
		if (req_take) begin
			kind_q    <= kind;
			handler_q <= handler;
			period_q  <= period;
			args_q    <= {arg_four, arg_three, arg_two, arg_one};
		end
		if (pend_load) begin
			pend_slot_q    <= idx_q;
			pend_handler_q <= rd_rec.handler;
			pend_args_q    <= rd_rec.args;
		end
	end

	// Output register: drop the held firing out, or build the final record
	always_ff @(posedge clk) begin
		if (push_mid || (push_fin && pend_valid_q)) begin
			status_q       <= STAT_OK;
			slot_out_q     <= 8'(pend_slot_q);
			fired_q        <= 1'b1;
			fire_handler_q <= pend_handler_q;
			fire_args_q    <= pend_args_q;
			last_q         <= push_fin;
		end else if (push_fin) begin
			status_q       <= fin_status_q;
			slot_out_q     <= fin_slot_q;
			fired_q        <= 1'b0;
			fire_handler_q <= '0;
			fire_args_q    <= '0;
			last_q         <= 1'b1;
		end
	end

	assign rsp_valid      = rsp_valid_q;
	assign status         = status_q;
	assign slot_out       = slot_out_q;
	assign fired          = fired_q;
	assign fire_handler   = fire_handler_q;
	assign fire_arg_one   = fire_args_q[0];
	assign fire_arg_two   = fire_args_q[1];
	assign fire_arg_three = fire_args_q[2];
	assign fire_arg_four  = fire_args_q[3];
	assign last           = last_q;

endmodule
